// ===== hw/rtl/kpbf_pkg.sv =====
// kpbf_pkg: shared types and constants for the position/bias filter
// no dependencies

package kpbf_pkg;

	localparam int FracBitsDefault = 16;
	localparam int GainFrac        = 30;
	localparam int CovW            = 48;
	localparam int NumRegs         = 3;

	// configuration register indexes
	localparam logic [1:0] RegNoisePos  = 2'd0;
	localparam logic [1:0] RegNoiseBias = 2'd1;
	localparam logic [1:0] RegNoiseMeas = 2'd2;

	localparam logic [31:0] NoiseReset = 32'd4294967;

	// multiply request to the shared unit: signed 33 x signed 49, floor shift
	typedef struct packed {
		logic               start;
		logic signed [32:0] a;
		logic signed [48:0] b;
		logic [5:0]         shift;
	} kpbf_mul_req_t;

	typedef struct packed {
		logic               done;
		logic signed [81:0] p;
	} kpbf_mul_rsp_t;

	// divide request: num * 2^30 / den, divided as |num| with the sign of num put back, den > 0
	typedef struct packed {
		logic               start;
		logic signed [48:0] num;
		logic signed [48:0] den;
	} kpbf_div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] q;
	} kpbf_div_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [81:0] v);
		if (v > 82'sd2147483647) return 32'sh7fffffff;
		if (v < -82'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [81:0] v);
		if (v > 82'sh7fffffffffff) return 48'sh7fffffffffff;
		if (v < -82'sh800000000000) return 48'sh800000000000;
		return v[47:0];
	endfunction

endpackage

// ===== hw/rtl/kpbf_mul.sv =====
// kpbf_mul: shared multiplier, one slice of operand b per cycle, floor shift at the end
// depends on kpbf_pkg

module kpbf_mul
	import kpbf_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  kpbf_mul_req_t req,
	output kpbf_mul_rsp_t rsp
);

	logic signed [32:0] a_q;
	logic signed [48:0] b_q;
	logic [5:0]         sh_q;
	logic signed [81:0] acc_q;
	logic [1:0]         cnt_q;
	logic               busy_q;
	logic               fin_q;
	logic               fin2_q;
	logic signed [16:0] slice;
	logic signed [49:0] part;
	logic signed [81:0] part_sh;

	// three slices of b: two unsigned 16-bit, top one signed 17-bit
	always_comb begin
		unique case (cnt_q)
			2'd0:    slice = $signed({1'b0, b_q[15:0]});
			2'd1:    slice = $signed({1'b0, b_q[31:16]});
			default: slice = b_q[48:32];
		endcase
		part    = 50'(a_q) * 50'(slice);
		part_sh = 82'(part) <<< {cnt_q, 4'd0};
	end

	// control: accumulate the three slices, then the shift step, then done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			fin2_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q  <= !req.start && busy_q && (cnt_q == 2'd2);
			fin2_q <= fin_q;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd2) busy_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			sh_q  <= req.shift;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + part_sh;
		end else if (fin_q) begin
			acc_q <= acc_q >>> sh_q;
		end
	end

	assign rsp.done = fin2_q;
	assign rsp.p    = acc_q;

endmodule

// ===== hw/rtl/kpbf_div.sv =====
// kpbf_div: restoring divider, one quotient bit per cycle
// depends on kpbf_pkg

module kpbf_div
	import kpbf_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  kpbf_div_req_t req,
	output kpbf_div_rsp_t rsp
);

	logic [48:0] d_q;
	logic [49:0] r_q;
	logic [48:0] n_q;
	logic [32:0] qt_q;
	logic        neg_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [49:0] r_sh;
	logic [48:0] nabs;

	always_comb begin
		nabs = req.num[48] ? 49'(-req.num) : 49'(req.num);
		r_sh = {r_q[48:0], n_q[48]};
	end

	// 49 integer steps then 30 fraction steps; quotient keeps 33 bits, sticky overflow
	logic ovf_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(48 + GainFrac)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			d_q   <= req.den;
			n_q   <= nabs;
			r_q   <= '0;
			qt_q  <= '0;
			ovf_q <= 1'b0;
			neg_q <= req.num[48];
		end else if (busy_q) begin
			n_q <= {n_q[47:0], 1'b0};
			if (qt_q[32]) ovf_q <= 1'b1;
			qt_q <= {qt_q[31:0], (r_sh >= 50'(d_q))};
			r_q  <= (r_sh >= 50'(d_q)) ? r_sh - 50'(d_q) : r_sh;
		end
	end

	logic [32:0] qmag;
	always_comb begin
		qmag = (ovf_q || qt_q[32] || qt_q[31]) ? 33'h7fffffff : qt_q;
		rsp.done = done_q;
		rsp.q    = neg_q ? -32'(qmag) : 32'(qmag);
	end

endmodule

// ===== hw/rtl/kalman_position_bias_filter.sv =====
// kalman_position_bias_filter: top level, sequencer over shared multiplier and divider
// depends on kpbf_pkg, kpbf_mul, kpbf_div
//
//  channel | dir | fields (low bit up)
//  s_axis  | in  | measured_position, measured_rate, time_step
//  m_axis  | out | filtered_position, unbiased_rate
//  cfg     | in  | noise registers by index
//
// each word from accept to the next ready takes ten passes of the
// shared multiplier, two divider runs and the output step
// when the innovation variance is not positive the divides are skipped
// reset clears estimates and covariance; noises return to 0.001
// a held result stalls the sequencer only once the next result is ready

module kalman_position_bias_filter
	import kpbf_pkg::*;
#(
	parameter int FRAC_BITS = FracBitsDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [79:0]  s_axis_tdata,  // measured_position, measured_rate, time_step
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata,  // filtered_position, unbiased_rate
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_wdata
);

	localparam int NoiseSh = 2 * FRAC_BITS - 32;

	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001, S_POS  = 12'b000000000010,
		S_D11  = 12'b000000000100, S_P00  = 12'b000000001000,
		S_P11  = 12'b000000010000, S_DIV0 = 12'b000000100000,
		S_DIV1 = 12'b000001000000, S_CP   = 12'b000010000000,
		S_CB   = 12'b000100000000, S_C0   = 12'b001000000000,
		S_C1   = 12'b010000000000, S_OUT  = 12'b100000000000
	} state_t;

	state_t state_q;
	logic [31:0] q_pos_q, q_bias_q, r_meas_q;
	logic signed [31:0] pos_q, bias_q, mp_q, rate_q, y_q, k0_q, k1_q;
	logic [15:0] dt_q;
	logic signed [47:0] p_q [4];
	logic signed [47:0] d11_q, p00o_q, p01o_q;
	logic [1:0] sub_q;
	logic issued_q;
	kpbf_mul_req_t mreq;
	kpbf_mul_rsp_t mrsp;
	kpbf_div_req_t dreq;
	kpbf_div_rsp_t drsp;
	logic signed [47:0] qp_cov, qb_cov, r_cov;
	logic signed [48:0] s_sum;
	logic out_full_q;

	function automatic logic signed [47:0] n2c(input logic [31:0] q);
		if (NoiseSh >= 0) return sat48(82'($unsigned(q)) <<< NoiseSh);
		return 48'($unsigned(q) >> (-NoiseSh));
	endfunction

	always_comb begin
		qp_cov = n2c(q_pos_q);
		qb_cov = n2c(q_bias_q);
		r_cov  = n2c(r_meas_q);
		s_sum  = 49'(p_q[0]) + 49'(r_cov);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_pos_q <= NoiseReset; q_bias_q <= NoiseReset; r_meas_q <= NoiseReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegNoisePos:  q_pos_q  <= cfg_wdata;
				RegNoiseBias: q_bias_q <= cfg_wdata;
				RegNoiseMeas: r_meas_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	kpbf_mul u_mul (.clk, .arst_n, .req(mreq), .rsp(mrsp));
	kpbf_div u_div (.clk, .arst_n, .req(dreq), .rsp(drsp));

	assign s_axis_tready = (state_q == S_IDLE);

	// operand selection per step
	always_comb begin
		mreq = '0;
		dreq = '0;
		mreq.start = !issued_q && state_q != S_IDLE && state_q != S_OUT
			&& state_q != S_DIV0 && state_q != S_DIV1;
		unique case (state_q)
			S_POS: begin mreq.a = 33'($unsigned(dt_q)); mreq.b = 49'(rate_q); mreq.shift = 6'd16; end
			S_D11: begin mreq.a = 33'($unsigned(dt_q)); mreq.b = 49'(p_q[3]); mreq.shift = 6'd16; end
			S_P00: begin mreq.a = 33'($unsigned(dt_q)); mreq.b = 49'(d11_q); mreq.shift = 6'd16; end
			S_P11: begin mreq.a = 33'($unsigned(dt_q)); mreq.b = 49'(qb_cov); mreq.shift = 6'd16; end
			S_CP:  begin mreq.a = 33'(k0_q); mreq.b = 49'(y_q); mreq.shift = 6'(GainFrac); end
			S_CB:  begin mreq.a = 33'(k1_q); mreq.b = 49'(y_q); mreq.shift = 6'(GainFrac); end
			S_C0:  begin
				mreq.a = 33'(k0_q); mreq.shift = 6'(GainFrac);
				mreq.b = sub_q[0] ? 49'(p01o_q) : 49'(p00o_q);
			end
			S_C1:  begin
				mreq.a = 33'(k1_q); mreq.shift = 6'(GainFrac);
				mreq.b = sub_q[0] ? 49'(p01o_q) : 49'(p00o_q);
			end
			default: ;
		endcase
		dreq.start = !issued_q && (state_q == S_DIV0 || state_q == S_DIV1);
		dreq.num   = (state_q == S_DIV1) ? 49'(p_q[2]) : 49'(p_q[0]);
		dreq.den   = s_sum;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; issued_q <= 1'b0; sub_q <= '0;
			pos_q <= '0; bias_q <= '0;
			for (int i = 0; i < 4; i++) p_q[i] <= '0;
			mp_q <= '0; dt_q <= '0; rate_q <= '0; y_q <= '0;
			k0_q <= '0; k1_q <= '0;
			d11_q <= '0; p00o_q <= '0; p01o_q <= '0;
			m_axis_tdata <= '0;
			out_full_q <= 1'b0;
		end else begin
			out_full_q <= (state_q == S_OUT) || (out_full_q && !m_axis_tready);
			if (mreq.start || dreq.start) issued_q <= 1'b1;
			unique case (state_q)
				S_IDLE: if (s_axis_tvalid) begin
					mp_q   <= s_axis_tdata[31:0];
					dt_q   <= s_axis_tdata[79:64];
					rate_q <= sat32(82'($signed(s_axis_tdata[63:32])) - 82'(bias_q));
					state_q <= S_POS; issued_q <= 1'b0;
				end
				S_POS: if (mrsp.done) begin
					pos_q <= sat32(82'(pos_q) + mrsp.p); state_q <= S_D11; issued_q <= 1'b0;
				end
				S_D11: if (mrsp.done) begin
					p_q[1] <= sat48(82'(p_q[1]) - mrsp.p);
					p_q[2] <= sat48(82'(p_q[2]) - mrsp.p);
					// d11 register holds the bracketed term
					d11_q <= sat48(mrsp.p - 82'(p_q[1]) - 82'(p_q[2]) + 82'(qp_cov));
					state_q <= S_P00; issued_q <= 1'b0;
				end
				S_P00: if (mrsp.done) begin
					p_q[0] <= sat48(82'(p_q[0]) + mrsp.p); state_q <= S_P11; issued_q <= 1'b0;
				end
				S_P11: if (mrsp.done) begin
					p_q[3] <= sat48(82'(p_q[3]) + mrsp.p);
					y_q <= sat32(82'(mp_q) - 82'(pos_q));
					if (s_sum > 0) begin state_q <= S_DIV0; end
					else begin k0_q <= '0; k1_q <= '0; state_q <= S_CP; end
					issued_q <= 1'b0;
				end
				S_DIV0: if (drsp.done) begin k0_q <= drsp.q; state_q <= S_DIV1; issued_q <= 1'b0; end
				S_DIV1: if (drsp.done) begin k1_q <= drsp.q; state_q <= S_CP; issued_q <= 1'b0; end
				S_CP: if (mrsp.done) begin
					pos_q <= sat32(82'(pos_q) + mrsp.p); state_q <= S_CB; issued_q <= 1'b0;
				end
				S_CB: if (mrsp.done) begin
					bias_q <= sat32(82'(bias_q) + mrsp.p);
					p00o_q <= p_q[0]; p01o_q <= p_q[1]; sub_q <= '0;
					state_q <= S_C0; issued_q <= 1'b0;
				end
				S_C0: if (mrsp.done) begin
					p_q[{1'b0, sub_q[0]}] <= sat48(82'(p_q[{1'b0, sub_q[0]}]) - mrsp.p);
					issued_q <= 1'b0;
					if (sub_q[0]) begin sub_q <= '0; state_q <= S_C1; end
					else sub_q <= 2'd1;
				end
				S_C1: if (mrsp.done) begin
					p_q[{1'b1, sub_q[0]}] <= sat48(82'(p_q[{1'b1, sub_q[0]}]) - mrsp.p);
					issued_q <= 1'b0;
					if (sub_q[0]) begin sub_q <= '0; state_q <= S_OUT; end
					else sub_q <= 2'd1;
				end
				S_OUT: if (!out_full_q || m_axis_tready) begin
					m_axis_tdata <= {rate_q, pos_q};
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_full_q;

endmodule

// ===== hw/rtl/kpbf_checker.sv =====
// kpbf_checker: port-level assertions for the filter
// depends on kalman_position_bias_filter ports

module kpbf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata
);

	// a taken word closes the input for the work
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("accept while busy");

	// held result keeps its data
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");

	// no result right after accept
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> ##1 !$rose(m_axis_tvalid)) else $error("early result");

endmodule

bind kalman_position_bias_filter kpbf_checker u_chk (.*);
